/* hdl/grs_pkg.sv */
// Package: shared types, constants and FSM states for the group reverse stream.
package grs_pkg;

    // Field widths fixed by the word formats
    localparam int VALUE_W   = 32;
    localparam int CFG_W     = 5;

    // Defaults
    localparam int MAX_GROUP_DEF  = 16;
    localparam logic [CFG_W-1:0] GROUP_SIZE_RST = CFG_W'(2);

    // Input word
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      final_item;
    } t_in_word;

    // Output word
    typedef struct packed {
        logic signed [VALUE_W-1:0] value_res;
        logic                      group_end;
        logic                      list_end;
    } t_out_word;

    // Controller states
    typedef enum logic [1:0] {
        ST_FILL,
        ST_READ,
        ST_SHOW
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic push;
        logic read;
        logic step;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic flush;
        logic idx_zero;
    } t_status;

endpackage

/* hdl/group_reverse_stream.sv */
// Top level: group reverse stream, controller plus datapath.
//
// Words are pushed into a group store, one per cycle, until the group size
// (register, clamped to 1..MAX_GROUP) is reached or a word flagged final_item
// arrives; the gathered group is then sent out newest first, the last word
// of each group carrying group_end and the last word of the list also
// list_end. Each result word is drained by a registered read of the group
// store RAM and is then presented, held through any output stall; no input
// word is taken while a group drains. The user must write the group size
// register only while the block is idle; the block does not enforce this.
module group_reverse_stream #(
    parameter int MAX_GROUP = grs_pkg::MAX_GROUP_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [grs_pkg::CFG_W-1:0]  i_cfg_wr_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  grs_pkg::t_in_word          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output grs_pkg::t_out_word         o_out_data
);
    import grs_pkg::*;

    t_cmd    cmd;
    t_status status;

    grs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    grs_datapath #(
        .MAX_GROUP (MAX_GROUP)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_data     (i_in_data),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_data    (o_out_data)
    );

endmodule

/* hdl/grs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module grs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, held between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/grs_datapath.sv */
// Datapath: group size register, fill counter, drain index and group store.
module grs_datapath #(
    parameter int MAX_GROUP = grs_pkg::MAX_GROUP_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [grs_pkg::CFG_W-1:0]  i_cfg_wr_data,
    input  grs_pkg::t_in_word          i_in_data,
    input  grs_pkg::t_cmd              i_cmd,
    output grs_pkg::t_status           o_status,
    output grs_pkg::t_out_word         o_out_data
);
    import grs_pkg::*;

    localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int FW = $clog2(MAX_GROUP + 1);
    localparam int CW = (FW > CFG_W) ? FW : CFG_W;

    logic [CFG_W-1:0] r_group_size;
    logic [FW-1:0]    r_fill, n_fill;
    logic [AW-1:0]    r_idx, n_idx;
    logic             r_last;
    logic [CW-1:0]    gs_ext;
    logic [CW-1:0]    eff_size;
    logic [CW-1:0]    count;
    logic [VALUE_W-1:0] rdata;

    // Hold the group size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= GROUP_SIZE_RST;
        end else if (i_cfg_wr_en) begin
            r_group_size <= i_cfg_wr_data;
        end
    end

    // Clamp group size into 1..MAX_GROUP
    always_comb begin
        gs_ext = CW'(r_group_size);
        if (gs_ext == '0) begin
            eff_size = CW'(1);
        end else if (gs_ext > CW'(MAX_GROUP)) begin
            eff_size = CW'(MAX_GROUP);
        end else begin
            eff_size = gs_ext;
        end
    end

    // Flush when the incoming word ends the list or completes the group
    assign count = CW'(r_fill) + CW'(1);
    assign o_status.flush    = i_in_data.final_item || (count >= eff_size);
    assign o_status.idx_zero = (r_idx == '0);

    // Advance fill count and drain index
    always_comb begin
        n_fill = r_fill;
        n_idx  = r_idx;
        if (i_cmd.push) begin
            if (o_status.flush) begin
                n_fill = '0;
                n_idx  = r_fill[AW-1:0];
            end else begin
                n_fill = r_fill + FW'(1);
            end
        end else if (i_cmd.step) begin
            n_idx = r_idx - AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.push) begin
            r_last <= i_in_data.final_item;
        end
    end

    // Group store
    grs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_GROUP),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_in_data.value),
        .i_re    (i_cmd.read),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    // Build the output word
    assign o_out_data.value_res = rdata;
    assign o_out_data.group_end = o_status.idx_zero;
    assign o_out_data.list_end  = o_status.idx_zero && r_last;

endmodule

/* hdl/grs_ctrl.sv */
// Controller: fill, read and present state machine for the group reverse stream.
module grs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  grs_pkg::t_status i_status,
    output grs_pkg::t_cmd    o_cmd
);
    import grs_pkg::*;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_FILL: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.push = 1'b1;
                    if (i_status.flush) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_SHOW;
            end
            ST_SHOW: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_status.idx_zero) begin
                        n_state = ST_FILL;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state    = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

endmodule

/* tb/sv/testbench.sv */
// Testbench for group_reverse_stream: directed and random lists checked against a group predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import grs_pkg::*;

    localparam int MAX_GROUP = MAX_GROUP_DEF;
    // Allow a full group drain plus margin
    localparam int SETTLE    = 2 * MAX_GROUP + 8;
    localparam int LIMIT     = 200000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]  cfg_wr_data = '0;
    logic              in_valid = 1'b0;
    logic              o_in_ready;
    t_in_word          in_data = '0;
    logic              o_out_valid;
    logic              out_ready = 1'b0;
    t_out_word         o_out_data;

    // Predictor state: words held for the current group and the size register
    logic signed [VALUE_W-1:0] held_words [MAX_GROUP];
    int unsigned               held_count = 0;
    logic [CFG_W-1:0]          group_size = GROUP_SIZE_RST;
    t_out_word                 reversed_words [$];

    int  mismatches = 0;
    int  cycle_count = 0;
    bit  no_idle = 1'b0;

    group_reverse_stream #(
        .MAX_GROUP (MAX_GROUP)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (in_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_out_data    (o_out_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Push one word and emit the held group newest first once it is complete
    function automatic void push_and_reverse(t_in_word w);
        int unsigned limit;
        t_out_word   r;
        limit = (group_size == 0) ? 1 : ((group_size > MAX_GROUP) ? MAX_GROUP : group_size);
        if (held_count >= MAX_GROUP) held_count = MAX_GROUP - 1;
        held_words[held_count] = w.value;
        held_count++;
        if (!w.final_item && held_count < limit) return;
        for (int k = int'(held_count) - 1; k >= 0; k--) begin
            r.value_res = held_words[k];
            r.group_end = (k == 0);
            r.list_end  = (k == 0) && w.final_item;
            reversed_words.push_back(r);
        end
        held_count = 0;
    endfunction

    function automatic void report_field(string name, logic [VALUE_W-1:0] exp_v,
                                         logic [VALUE_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // Track config and input words, compare each output word with the oldest expectation
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            held_count = 0;
            group_size = GROUP_SIZE_RST;
        end else begin
            if (cfg_wr_en) group_size = cfg_wr_data;
            if (in_valid && o_in_ready) push_and_reverse(in_data);
            if (o_out_valid && out_ready) begin
                if (reversed_words.size() == 0) begin
                    $display("%0t: unexpected word: expected none actual %h", $time,
                             o_out_data);
                    mismatches++;
                end else begin
                    want = reversed_words.pop_front();
                    report_field("value_res", want.value_res, o_out_data.value_res);
                    report_field("group_end", VALUE_W'(want.group_end),
                                 VALUE_W'(o_out_data.group_end));
                    report_field("list_end", VALUE_W'(want.list_end),
                                 VALUE_W'(o_out_data.list_end));
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Output side: stall a random number of cycles before each word
    initial begin : result_sink
        int stall;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_rst_n));
        end
    end

    // Send one word after a random gap and hold it until accepted
    task automatic send_word(input logic signed [VALUE_W-1:0] v, input logic fin);
        int       gap;
        t_in_word w;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        w.value = v;
        w.final_item = fin;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Hold off the sender until every expected word has come out
    task automatic await_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (reversed_words.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Write the group size once the block is idle
    task automatic set_group_size(input logic [CFG_W-1:0] n);
        await_results();
        repeat (SETTLE) @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    // Reset size of two with a trailing partial group
    task automatic test_default_size();
        send_word(32'sh8000_0000, 1'b0);
        send_word(32'sh7fff_ffff, 1'b0);
        send_word(32'sh0000_0000, 1'b0);
        send_word(-1, 1'b0);
        send_word(32'sh0000_0001, 1'b1);
    endtask

    // Smallest and largest group sizes
    task automatic test_size_extremes();
        set_group_size(CFG_W'(1));
        send_word(32'sh1234_5678, 1'b0);
        send_word(32'shfedc_ba98, 1'b1);
        set_group_size(CFG_W'(MAX_GROUP));
        for (int i = 0; i < MAX_GROUP; i++) send_word($urandom, 1'b0);
        send_word($urandom, 1'b1);
    endtask

    // Shrink the size while a group is partly held: the next word flushes all
    task automatic test_size_lowered();
        set_group_size(CFG_W'(8));
        send_word(32'sh0000_0011, 1'b0);
        send_word(32'sh0000_0022, 1'b0);
        send_word(32'sh0000_0033, 1'b0);
        set_group_size(CFG_W'(2));
        send_word(32'sh0000_0044, 1'b0);
        send_word(32'sh0000_0055, 1'b1);
    endtask

    // Random lists over random sizes, some without a final word
    task automatic test_random_lists();
        int               sent;
        int               lists;
        int               len;
        bit               broken;
        logic [CFG_W-1:0] sz;
        sent = 0;
        while (sent < 70) begin
            case ($urandom_range(0, 5))
                0:       sz = CFG_W'(1);
                1:       sz = CFG_W'(MAX_GROUP);
                default: sz = CFG_W'($urandom_range(1, MAX_GROUP));
            endcase
            set_group_size(sz);
            no_idle = ($urandom_range(0, 3) == 0);
            lists = $urandom_range(1, 3);
            repeat (lists) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40)
                                                  : $urandom_range(1, 12);
                broken = ($urandom_range(0, 7) == 0);
                for (int i = 0; i < len; i++) begin
                    send_word(pick_value(), (i == len - 1) && !broken);
                    sent++;
                end
                if ($urandom_range(0, 4) == 0) await_results();
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_size();
        test_size_extremes();
        test_size_lowered();
        test_random_lists();
        await_results();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && reversed_words.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/grs_pkg.sv
hdl/grs_ram.sv
hdl/grs_datapath.sv
hdl/grs_ctrl.sv
hdl/group_reverse_stream.sv
tb/sv/testbench.sv
